[hdl/qmfs_pkg.sv]
// shared constants, coefficient table and control types for the two-band qmf synthesis block
package qmfs_pkg;

    localparam int TAPS            = 48;
    localparam int HALF_TAPS       = TAPS / 2;
    localparam int PAIR_W          = $clog2(HALF_TAPS);
    localparam int TAP_IDX_W       = $clog2(TAPS);
    localparam int COEF_W          = 18;
    localparam int COEF_FRAC       = 17;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam logic signed [COEF_W-1:0] HALF_COEF [HALF_TAPS] = '{
        -18'sd4,     -18'sd24,    -18'sd15,    18'sd79,
        18'sd64,     -18'sd224,   -18'sd136,   18'sd533,
        18'sd205,    -18'sd1105,  -18'sd198,   18'sd2055,
        -18'sd16,    -18'sd3524,  18'sd646,    18'sd5698,
        -18'sd2045,  -18'sd8937,  18'sd4931,   18'sd14241,
        -18'sd11429, -18'sd26053, 18'sd34624,  18'sd121698
    };

    typedef struct packed {
        logic              load;
        logic              step;
        logic              out_load;
        logic [PAIR_W-1:0] pair_idx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // mirrored window coefficient for tap idx
    function automatic logic signed [COEF_W-1:0] win_coef(input logic [TAP_IDX_W-1:0] idx);
        logic [TAP_IDX_W-1:0] k;
        k = (idx < TAP_IDX_W'(HALF_TAPS)) ? idx : TAP_IDX_W'(TAPS - 1) - idx;
        return HALF_COEF[k[PAIR_W-1:0]];
    endfunction

endpackage

[hdl/qmfs_ctrl.sv]
// controller state machine sequencing the tap-pair walk of the qmf synthesis block
module qmfs_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  qmfs_pkg::dp_status_t   status,
    output qmfs_pkg::ctrl_cmd_t    cmd
);
    import qmfs_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        RUN,
        DRAIN,
        FINISH
    } state_t;

    localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(HALF_TAPS - 1);

    state_t            state_reg;
    state_t            state_next;
    logic [PAIR_W-1:0] cnt_reg;
    logic [PAIR_W-1:0] cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_ready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.out_load = 1'b0;
        cmd.pair_idx = cnt_reg;
        unique case (state_reg)
            IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = RUN;
                end
            end
            RUN:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + PAIR_W'(1);
                if (cnt_reg == LAST_PAIR)
                begin
                    cnt_next   = '0;
                    state_next = DRAIN;
                end
            end
            DRAIN:
            begin
                state_next = FINISH;
            end
            FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_load_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (cmd.step && cnt_reg == '0))
        else $error("tap walk did not start after request load");
    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && cnt_reg == LAST_PAIR) |=> (state_reg == DRAIN))
        else $error("tap walk did not end after last pair");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded into busy output register");
`endif

endmodule

[hdl/qmfs_datapath.sv]
// window shift line, dual multiply-accumulate and output register of the qmf synthesis block
module qmfs_datapath
#(
    parameter int SAMPLE_BITS = qmfs_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  qmfs_pkg::ctrl_cmd_t           cmd,
    output qmfs_pkg::dp_status_t          status,
    input  logic signed [SAMPLE_BITS-1:0] low_sample,
    input  logic signed [SAMPLE_BITS-1:0] high_sample,
    input  logic                          frame_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] first_out,
    output logic signed [SAMPLE_BITS-1:0] second_out,
    output logic                          frame_end_out
);
    import qmfs_pkg::*;

    localparam int HIST_W = SAMPLE_BITS + 1;
    localparam int PROD_W = HIST_W + COEF_W;
    localparam int ACC_W  = PROD_W + PAIR_W;
    localparam int RES_W  = ACC_W - COEF_FRAC;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [RES_W-1:0] SAT_MAX    =
        RES_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [RES_W-1:0] SAT_MIN    = -SAT_MAX - RES_W'(1);

    logic signed [HIST_W-1:0]      win_reg [TAPS];
    logic signed [HIST_W-1:0]      win_next [TAPS];
    logic signed [PROD_W-1:0]      prod_even_reg;
    logic signed [PROD_W-1:0]      prod_odd_reg;
    logic                          prod_valid_reg;
    logic signed [ACC_W-1:0]       acc_even_reg;
    logic signed [ACC_W-1:0]       acc_odd_reg;
    logic                          frame_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] first_reg;
    logic signed [SAMPLE_BITS-1:0] second_reg;
    logic                          frame_out_reg;
    logic signed [COEF_W-1:0]      coef_even;
    logic signed [COEF_W-1:0]      coef_odd;
    logic signed [SAMPLE_BITS-1:0] first_sat;
    logic signed [SAMPLE_BITS-1:0] second_sat;

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] biased;
        logic signed [RES_W-1:0] res;
        biased = acc + ROUND_BIAS;
        res    = biased[ACC_W-1:COEF_FRAC];
        if (res > SAT_MAX)
        begin
            return SAT_MAX[SAMPLE_BITS-1:0];
        end
        else if (res < SAT_MIN)
        begin
            return SAT_MIN[SAMPLE_BITS-1:0];
        end
        return res[SAMPLE_BITS-1:0];
    endfunction

    assign coef_even = win_coef({cmd.pair_idx, 1'b0});
    assign coef_odd  = win_coef({cmd.pair_idx, 1'b1});

    // load appends sum and difference; a step rotates the oldest pair to the end
    always_comb
    begin
        for (int i = 0; i < TAPS - 2; i++)
        begin
            win_next[i] = win_reg[i + 2];
        end
        if (cmd.load)
        begin
            win_next[TAPS-2] = HIST_W'(low_sample) + HIST_W'(high_sample);
            win_next[TAPS-1] = HIST_W'(low_sample) - HIST_W'(high_sample);
        end
        else
        begin
            win_next[TAPS-2] = win_reg[0];
            win_next[TAPS-1] = win_reg[1];
        end
    end

    assign first_sat  = round_sat(acc_odd_reg);
    assign second_sat = round_sat(acc_even_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                win_reg[i] <= '0;
            end
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load || cmd.step)
            begin
                win_reg <= win_next;
            end
            prod_valid_reg <= cmd.step;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            prod_even_reg <= win_reg[0] * coef_even;
            prod_odd_reg  <= win_reg[1] * coef_odd;
        end
        if (cmd.load)
        begin
            acc_even_reg <= '0;
            acc_odd_reg  <= '0;
            frame_reg    <= frame_end;
        end
        else if (prod_valid_reg)
        begin
            acc_even_reg <= acc_even_reg + ACC_W'(prod_even_reg);
            acc_odd_reg  <= acc_odd_reg + ACC_W'(prod_odd_reg);
        end
        if (cmd.out_load)
        begin
            first_reg     <= first_sat;
            second_reg    <= second_sat;
            frame_out_reg <= frame_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign first_out       = first_reg;
    assign second_out      = second_reg;
    assign frame_end_out   = frame_out_reg;

`ifndef SYNTHESIS
    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("output valid missing after result load");
    a_step_makes_product: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> prod_valid_reg)
        else $error("product not marked after step");
`endif

endmodule

[hdl/two_band_qmf_synthesis.sv]
// two-band qmf synthesis, 48-tap symmetric window, shared dual multiply-accumulate
//
// usage:
//   slave channel s_*: one request carries a low-band and a high-band sample
//   (s_tdata) and the frame marker (s_tlast). master channel m_*: one result
//   per request, the earlier and later output samples (m_tdata), rounded and
//   saturated, with the frame marker copied to m_tlast.
//   each item is handled in order: accept, walk the 24 tap pairs
//   through the two shared multipliers, drain the product register, then
//   round, saturate and load the output register. most of the work is the
//   tap-pair walk over the window shift line.
//   m_tvalid rises once the result is loaded; s_tready is high only
//   while no item is in work, so the next request is taken only after the
//   previous result has been loaded into the output register.
//   reset clears the window history to zero and empties the output register.
//   if the receiver stalls, the result waits in the output register while the
//   next request is accepted and processed; that result then waits for the
//   output register to empty and s_tready stays low until it does.
module two_band_qmf_synthesis
#(
    parameter int SAMPLE_BITS = qmfs_pkg::SAMPLE_BITS_DEF,
    parameter int DATA_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // low_sample, high_sample, zero pad
    input  logic              s_tlast,   // frame_end
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // first_out, second_out, zero pad
    output logic              m_tlast    // frame_end_out
);
    import qmfs_pkg::*;

    ctrl_cmd_t                     cmd;
    dp_status_t                    status;
    logic signed [SAMPLE_BITS-1:0] low_sample;
    logic signed [SAMPLE_BITS-1:0] high_sample;
    logic signed [SAMPLE_BITS-1:0] first_out;
    logic signed [SAMPLE_BITS-1:0] second_out;

    assign low_sample  = s_tdata[SAMPLE_BITS-1:0];
    assign high_sample = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign m_tdata     = DATA_W'({second_out, first_out});

    qmfs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qmfs_datapath
    #(
        .SAMPLE_BITS (SAMPLE_BITS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .low_sample    (low_sample),
        .high_sample   (high_sample),
        .frame_end     (s_tlast),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .first_out     (first_out),
        .second_out    (second_out),
        .frame_end_out (m_tlast)
    );

endmodule
